// ----- design/dte_pkg.sv -----
`timescale 1ns / 1ps

package dte_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int FD_W        = 8;
  localparam int RFD_W       = 4;
  localparam int OP_W        = 3;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN_AT     = 3'd0,
    OP_ADD_LOWEST  = 3'd1,
    OP_CLOSE       = 3'd2,
    OP_DUP         = 3'd3,
    OP_REQUEST_EOF = 3'd4,
    OP_TAKE_EOF    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TGT,
    ST_RD_SRC,
    ST_SCAN,
    ST_EXEC
  } state_t;

  function automatic logic fd_in_range(input logic [FD_W-1:0] fd);
    fd_in_range = !fd[FD_W-1] && ({1'b0, fd[FD_W-2:0]} < FD_W'(TABLE_SLOTS));
  endfunction

endpackage

// ----- design/dte_ram.sv -----
`timescale 1ns / 1ps

module dte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/descriptor_table_engine_unit.sv -----
`timescale 1ns / 1ps
// channel | signals                                         | dir
// in      | in_valid in_ready op fd_index source_fd handle  | in
// out     | out_valid out_ready status result_fd eof_taken  | out
//         | ref_up_valid ref_up_handle ref_down_valid ref_down_handle
//
// One word at a time: each word passes RD_TGT, RD_SRC and EXEC; add_lowest with a nonzero handle
// also runs SCAN, visiting 1 to TABLE_SLOTS slots from slot 0, one slot per cycle.
// Handle reads go through the single read port of the slot RAM, one per cycle.
// Sync reset empties the table at once through per-slot busy bits.
// A waiting result does not block the next word; a full output holds EXEC.

module descriptor_table_engine_unit
  import dte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic signed [FD_W-1:0] fd_index,
  input  logic signed [FD_W-1:0] source_fd,
  input  logic [15:0]            handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   status,
  output logic [RFD_W-1:0]       result_fd,
  output logic                   eof_taken,
  output logic                   ref_up_valid,
  output logic [15:0]            ref_up_handle,
  output logic                   ref_down_valid,
  output logic [15:0]            ref_down_handle
);

  state_t state, state_next;

  logic [OP_W-1:0]        op_r;
  logic [FD_W-1:0]        tgt_fd, src_fd;
  logic [HANDLE_BITS-1:0] h_r;
  logic [HANDLE_BITS-1:0] tgt_h;
  logic [TABLE_SLOTS-1:0] busy, eof;
  logic [SLOT_W-1:0]      scan_idx;
  logic                   found;
  logic [SLOT_W-1:0]      found_slot;

  logic [SLOT_W-1:0]      tgt_slot, src_slot;
  logic                   tgt_ok, src_ok, tgt_busy, src_busy;
  logic [HANDLE_BITS-1:0] src_h;
  logic                   exec_go;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
  logic [HANDLE_BITS-1:0] ram_wdata, ram_rdata;

  logic                   err, taken, upv, dnv;
  logic [SLOT_W-1:0]      rfd;
  logic [HANDLE_BITS-1:0] uph, dnh;
  logic                   busy_we, busy_val, eof_we, eof_val;
  logic [SLOT_W-1:0]      upd_slot;

  assign tgt_slot = tgt_fd[SLOT_W-1:0];
  assign src_slot = src_fd[SLOT_W-1:0];
  assign tgt_ok   = fd_in_range(tgt_fd);
  assign src_ok   = fd_in_range(src_fd);
  assign tgt_busy = tgt_ok && busy[tgt_slot];
  assign src_busy = src_ok && busy[src_slot];
  assign src_h    = ram_rdata;
  assign exec_go  = !out_valid || out_ready;

  dte_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RD_TGT;
        end
      end
      ST_RD_TGT: state_next = ST_RD_SRC;
      ST_RD_SRC: begin
        if (op_r == OP_ADD_LOWEST && h_r != '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (!busy[scan_idx] || scan_idx == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    ram_raddr = (state == ST_RD_TGT) ? tgt_slot : src_slot;
  end

  always_comb begin
    err      = 1'b0;
    taken    = 1'b0;
    upv      = 1'b0;
    dnv      = 1'b0;
    uph      = '0;
    dnh      = '0;
    rfd      = '0;
    busy_we  = 1'b0;
    busy_val = 1'b0;
    eof_we   = 1'b0;
    eof_val  = 1'b0;
    upd_slot = tgt_slot;
    ram_we   = 1'b0;
    ram_wdata = h_r;
    case (op_r)
      OP_OPEN_AT: begin
        if (h_r == '0 || !tgt_ok || tgt_busy) begin
          err = 1'b1;
        end else begin
          ram_we   = 1'b1;
          busy_we  = 1'b1;
          busy_val = 1'b1;
          eof_we   = 1'b1;
          upv      = 1'b1;
          uph      = h_r;
          rfd      = tgt_slot;
        end
      end
      OP_ADD_LOWEST: begin
        upd_slot = found_slot;
        if (h_r == '0 || !found) begin
          err = 1'b1;
        end else begin
          ram_we   = 1'b1;
          busy_we  = 1'b1;
          busy_val = 1'b1;
          eof_we   = 1'b1;
          upv      = 1'b1;
          uph      = h_r;
          rfd      = found_slot;
        end
      end
      OP_CLOSE: begin
        if (!tgt_busy) begin
          err = 1'b1;
        end else begin
          busy_we = 1'b1;
          eof_we  = 1'b1;
          dnv     = 1'b1;
          dnh     = tgt_h;
        end
      end
      OP_DUP: begin
        if (!tgt_ok) begin
          err = 1'b1;
        end else begin
          rfd = tgt_slot;
          if (src_fd != tgt_fd) begin
            busy_we  = tgt_busy || src_busy;
            busy_val = src_busy;
            eof_we   = tgt_busy || src_busy;
            dnv      = tgt_busy;
            dnh      = tgt_busy ? tgt_h : '0;
            upv      = src_busy;
            uph      = src_busy ? src_h : '0;
            ram_we   = src_busy;
            ram_wdata = src_h;
          end
        end
      end
      OP_REQUEST_EOF: begin
        if (!tgt_busy) begin
          err = 1'b1;
        end else begin
          eof_we  = 1'b1;
          eof_val = 1'b1;
        end
      end
      OP_TAKE_EOF: begin
        if (!tgt_busy) begin
          err = 1'b1;
        end else if (eof[tgt_slot]) begin
          eof_we = 1'b1;
          taken  = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
    if (state != ST_EXEC || !exec_go) begin
      ram_we  = 1'b0;
      busy_we = 1'b0;
      eof_we  = 1'b0;
    end
    ram_waddr = upd_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= '0;
      eof       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (busy_we) begin
        busy[upd_slot] <= busy_val;
      end
      if (eof_we) begin
        eof[upd_slot] <= eof_val;
      end
      if (state == ST_EXEC && exec_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= op;
      tgt_fd <= fd_index;
      src_fd <= source_fd;
      h_r    <= handle[HANDLE_BITS-1:0];
    end
    if (state == ST_RD_SRC) begin
      tgt_h    <= ram_rdata;
      scan_idx <= '0;
      found    <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (!busy[scan_idx]) begin
        found      <= 1'b1;
        found_slot <= scan_idx;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (state == ST_EXEC && exec_go) begin
      status          <= err;
      result_fd       <= err ? '0 : RFD_W'(rfd);
      eof_taken       <= !err && taken;
      ref_up_valid    <= !err && upv;
      ref_up_handle   <= err ? '0 : 16'(uph);
      ref_down_valid  <= !err && dnv;
      ref_down_handle <= err ? '0 : 16'(dnh);
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result_fd == '0 && !eof_taken && !ref_up_valid && !ref_down_valid)
    else $error("error word carries payload");

  a_up_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ref_up_valid |-> ref_up_handle != '0)
    else $error("reference gained on empty handle");

  a_take_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && eof_taken |-> !ref_up_valid && !ref_down_valid)
    else $error("eof take with reference event");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

endmodule

// ----- dv/descriptor_table_engine_unit_tb.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  logic        status;
  logic [3:0]  result_fd;
  logic        eof_taken;
  logic        up_valid;
  logic [15:0] up_handle;
  logic        down_valid;
  logic [15:0] down_handle;
} fd_result_t;

class fd_table_shadow;
  logic [15:0] slot_handle [dte_pkg::TABLE_SLOTS];
  bit          eof_req [dte_pkg::TABLE_SLOTS];
  fd_result_t  pending_results [$];
  int          errors;

  function new();
    foreach (slot_handle[i]) begin
      slot_handle[i] = '0;
      eof_req[i] = 1'b0;
    end
    errors = 0;
  endfunction

  function bit in_table(int fd);
    return fd >= 0 && fd < dte_pkg::TABLE_SLOTS;
  endfunction

  function bit busy(int fd);
    return in_table(fd) && slot_handle[fd] != 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // one accepted word -> one expected result
  function void note_word(logic [2:0] op_code, logic signed [7:0] tgt_fd,
                          logic signed [7:0] src_fd, logic [15:0] h_in);
    fd_result_t  r;
    int          t;
    int          s;
    int          i;
    logic [15:0] h;
    bit          fail;
    r = '0;
    fail = 1'b0;
    t = tgt_fd;
    s = src_fd;
    h = h_in & 16'((64'h1 << dte_pkg::HANDLE_BITS) - 1);
    case (op_code)
      dte_pkg::OP_OPEN_AT: begin
        if (h == 0 || !in_table(t) || busy(t)) begin
          fail = 1'b1;
        end else begin
          slot_handle[t] = h;
          eof_req[t] = 1'b0;
          r.up_valid = 1'b1;
          r.up_handle = h;
          r.result_fd = t[3:0];
        end
      end
      dte_pkg::OP_ADD_LOWEST: begin
        fail = 1'b1;
        for (i = 0; h != 0 && fail && i < dte_pkg::TABLE_SLOTS; i++) begin
          if (slot_handle[i] == 0) begin
            slot_handle[i] = h;
            eof_req[i] = 1'b0;
            r.up_valid = 1'b1;
            r.up_handle = h;
            r.result_fd = i[3:0];
            fail = 1'b0;
          end
        end
      end
      dte_pkg::OP_CLOSE: begin
        if (!busy(t)) begin
          fail = 1'b1;
        end else begin
          r.down_valid = 1'b1;
          r.down_handle = slot_handle[t];
          slot_handle[t] = '0;
          eof_req[t] = 1'b0;
        end
      end
      dte_pkg::OP_DUP: begin
        if (!in_table(t)) begin
          fail = 1'b1;
        end else begin
          r.result_fd = t[3:0];
          if (s != t) begin
            if (busy(t)) begin
              r.down_valid = 1'b1;
              r.down_handle = slot_handle[t];
              slot_handle[t] = '0;
              eof_req[t] = 1'b0;
            end
            if (busy(s)) begin
              slot_handle[t] = slot_handle[s];
              eof_req[t] = 1'b0;
              r.up_valid = 1'b1;
              r.up_handle = slot_handle[s];
            end
          end
        end
      end
      dte_pkg::OP_REQUEST_EOF: begin
        if (!busy(t)) fail = 1'b1;
        else eof_req[t] = 1'b1;
      end
      dte_pkg::OP_TAKE_EOF: begin
        if (!busy(t)) begin
          fail = 1'b1;
        end else if (eof_req[t]) begin
          eof_req[t] = 1'b0;
          r.eof_taken = 1'b1;
        end
      end
      default: fail = 1'b1;
    endcase
    if (fail) begin
      r = '0;
      r.status = 1'b1;
    end
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(fd_result_t got);
    fd_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result word with nothing outstanding");
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    compare_field("status", exp_r.status, got.status);
    compare_field("result_fd", exp_r.result_fd, got.result_fd);
    compare_field("eof_taken", exp_r.eof_taken, got.eof_taken);
    compare_field("ref_up_valid", exp_r.up_valid, got.up_valid);
    compare_field("ref_up_handle", exp_r.up_handle, got.up_handle);
    compare_field("ref_down_valid", exp_r.down_valid, got.down_valid);
    compare_field("ref_down_handle", exp_r.down_handle, got.down_handle);
  endfunction
endclass

module descriptor_table_engine_unit_tb;
  import dte_pkg::*;

  localparam logic [2:0] OP_BAD_6 = 3'd6;
  localparam logic [2:0] OP_BAD_7 = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_PHASES = 13;
  localparam int         WORDS_PER_PHASE = 50;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   op;
  logic [FD_W-1:0]   fd_index;
  logic [FD_W-1:0]   source_fd;
  logic [15:0]       handle;
  logic              out_valid;
  logic              out_ready;
  logic              status;
  logic [RFD_W-1:0]  result_fd;
  logic              eof_taken;
  logic              ref_up_valid;
  logic [15:0]       ref_up_handle;
  logic              ref_down_valid;
  logic [15:0]       ref_down_handle;

  bit                steady;
  int                ready_hold;
  fd_table_shadow    table_shadow;

  descriptor_table_engine_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .fd_index       (fd_index),
    .source_fd      (source_fd),
    .handle         (handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_fd      (result_fd),
    .eof_taken      (eof_taken),
    .ref_up_valid   (ref_up_valid),
    .ref_up_handle  (ref_up_handle),
    .ref_down_valid (ref_down_valid),
    .ref_down_handle(ref_down_handle)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_fd();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, TABLE_SLOTS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // mix 0 fills the table, mix 1 empties it, mix 2 is balanced
  function automatic logic [2:0] pick_op(int mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? OP_BAD_6 : OP_BAD_7;
    r = $urandom_range(0, 99);
    case (mix)
      0: begin
        if (r < 40) return OP_ADD_LOWEST;
        if (r < 55) return OP_OPEN_AT;
        if (r < 65) return OP_DUP;
        if (r < 75) return OP_REQUEST_EOF;
        if (r < 88) return OP_TAKE_EOF;
        return OP_CLOSE;
      end
      1: begin
        if (r < 40) return OP_CLOSE;
        if (r < 55) return OP_DUP;
        if (r < 65) return OP_ADD_LOWEST;
        if (r < 75) return OP_OPEN_AT;
        if (r < 85) return OP_REQUEST_EOF;
        return OP_TAKE_EOF;
      end
      default: begin
        if (r < 18) return OP_OPEN_AT;
        if (r < 34) return OP_ADD_LOWEST;
        if (r < 50) return OP_CLOSE;
        if (r < 66) return OP_DUP;
        if (r < 83) return OP_REQUEST_EOF;
        return OP_TAKE_EOF;
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(logic [2:0] op_code, logic [7:0] tgt_fd,
                           logic [7:0] src_fd, logic [15:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_code;
    fd_index  <= tgt_fd;
    source_fd <= src_fd;
    handle    <= h;
    do @(posedge clk); while (!in_ready);
    table_shadow.note_word(op_code, tgt_fd, src_fd, h);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_shadow.pending() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    ready_hold = 0;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0:       begin out_ready <= 1'b0; ready_hold = $urandom_range(10, 40); end
          1,2,3,4: begin out_ready <= 1'b0; ready_hold = $urandom_range(0, 3); end
          default: begin out_ready <= 1'b1; ready_hold = $urandom_range(0, 7); end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      table_shadow.check_result({status, result_fd, eof_taken, ref_up_valid,
                                 ref_up_handle, ref_down_valid, ref_down_handle});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("descriptor_table_engine_unit regression: fail");
    $finish;
  end

  initial begin
    int ph;
    int n;
    table_shadow = new();
    steady = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    op        <= '0;
    fd_index  <= '0;
    source_fd <= '0;
    handle    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: range edges, zero handle, busy/empty slots, dup corner cases
    send_word(OP_OPEN_AT, 8'd0, 8'd0, 16'hFFFF);
    send_word(OP_OPEN_AT, 8'd15, 8'hFF, 16'h0001);
    send_word(OP_OPEN_AT, 8'd16, 8'd0, 16'h1111);
    send_word(OP_OPEN_AT, 8'hFF, 8'd0, 16'h2222);
    send_word(OP_OPEN_AT, 8'h80, 8'h80, 16'h3333);
    send_word(OP_OPEN_AT, 8'h7F, 8'h7F, 16'h4444);
    send_word(OP_OPEN_AT, 8'd3, 8'd0, 16'h0000);
    send_word(OP_OPEN_AT, 8'd0, 8'd0, 16'h1234);
    send_word(OP_ADD_LOWEST, 8'd0, 8'd0, 16'h0000);
    send_word(OP_ADD_LOWEST, 8'hAA, 8'h55, 16'hA5A5);
    send_word(OP_CLOSE, 8'd5, 8'd0, 16'h0000);
    send_word(OP_REQUEST_EOF, 8'd5, 8'd0, 16'h0000);
    send_word(OP_TAKE_EOF, 8'd7, 8'd0, 16'h0000);
    send_word(OP_REQUEST_EOF, 8'd0, 8'd0, 16'h0000);
    send_word(OP_TAKE_EOF, 8'd0, 8'd0, 16'h0000);
    send_word(OP_TAKE_EOF, 8'd0, 8'd0, 16'h0000);
    send_word(OP_DUP, 8'd4, 8'd4, 16'h0000);
    send_word(OP_DUP, 8'd0, 8'd0, 16'h0000);
    send_word(OP_REQUEST_EOF, 8'd15, 8'd0, 16'h0000);
    send_word(OP_DUP, 8'd15, 8'd0, 16'h0000);
    send_word(OP_TAKE_EOF, 8'd15, 8'd0, 16'h0000);
    send_word(OP_DUP, 8'd1, 8'd9, 16'h0000);
    send_word(OP_DUP, 8'd2, 8'hFB, 16'h0000);
    send_word(OP_DUP, 8'd16, 8'd0, 16'h0000);
    send_word(OP_DUP, 8'hFF, 8'd0, 16'h0000);
    send_word(OP_CLOSE, 8'd0, 8'd0, 16'h0000);
    send_word(OP_BAD_6, 8'd0, 8'd0, 16'hFFFF);
    send_word(OP_BAD_7, 8'd15, 8'd15, 16'h0001);
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph % 4 == 3);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(pick_op(ph % 3), pick_fd(), pick_fd(), pick_handle());
      end
      if (ph % 5 == 4) wait_drained();
    end
    steady = 1'b0;

    wait_drained();
    repeat (24) @(posedge clk);
    if (table_shadow.errors == 0 && table_shadow.pending() == 0) begin
      $display("descriptor_table_engine_unit regression: pass");
    end else begin
      $display("descriptor_table_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- descriptor_table_engine_unit.f -----
design/dte_pkg.sv
design/dte_ram.sv
design/descriptor_table_engine_unit.sv
dv/descriptor_table_engine_unit_tb.sv
